[sv/tce_pkg.sv]
// Shared types and constants for the toy CPU execute block.
// No dependencies.
package tce_pkg;

    localparam int PC_W     = 11;
    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 8;
    localparam int MEM_BYTES = 256;
    localparam int CNT_W    = 32;

    localparam logic [CNT_W-1:0] FIRST_TOUCH_COST = 32'd50;
    localparam logic [CNT_W-1:0] LOCAL_HIT_COST   = 32'd2;
    localparam logic [CNT_W-1:0] PLAIN_COST       = 32'd1;

    typedef enum logic [2:0] {
        K_MOV     = 3'd0,
        K_ADD_REG = 3'd1,
        K_ADD_IMM = 3'd2,
        K_CMP     = 3'd3,
        K_JE      = 3'd4,
        K_JMP     = 3'd5,
        K_LD      = 3'd6,
        K_ST      = 3'd7
    } t_kind;

    // data memory request from the execute logic
    typedef struct packed {
        logic              touch;
        logic              wr;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_mem_req;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? '1 : s[CNT_W-1:0];
    endfunction

endpackage

[sv/tce_dmem.sv]
// Data memory with per-byte touched bits for the toy CPU execute block.
// Depends on tce_pkg.
module tce_dmem
    import tce_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mem_req          i_req,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [BYTE_W-1:0] o_rd_data,
    output logic              o_touched
);

    logic [BYTE_W-1:0] r_mem [MEM_BYTES];
    logic [MEM_BYTES-1:0] r_touched;
    logic [BYTE_W-1:0] r_rd_data;
    logic              r_rd_touched;

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[i_req.addr] <= i_req.data;
        end
        // write-through so the next item sees this store
        if (i_req.wr && (i_req.addr == i_rd_addr)) begin
            r_rd_data <= i_req.data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touched    <= '0;
            r_rd_touched <= 1'b0;
        end else begin
            if (i_req.touch) begin
                r_touched[i_req.addr] <= 1'b1;
            end
            r_rd_touched <= (i_req.touch && (i_req.addr == i_rd_addr)) ||
                            r_touched[i_rd_addr];
        end
    end

    assign o_touched = r_rd_touched;
    assign o_rd_data = r_rd_data;

endmodule

[sv/toy_cpu_execute_with_touch_cost_top.sv]
// Toy CPU execute block: register file, flag, pc and saturating counters.
// Depends on tce_pkg and tce_dmem.
// Registers: input stage for the accepted item, then result register.
// Throughput: one item per cycle unless the output stalls; register file and data
// memory are read in the cycle before, forwarding writes of the executing item.
// Reset (sync, active low): registers, flag, pc, counters, touched bits and
// program length cleared; memory bytes read as zero until touched.
module toy_cpu_execute_with_touch_cost_top
    import tce_pkg::*;
#(
    parameter int NUM_REGISTERS = 6,
    parameter int MAX_PROGRAM   = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [PC_W-1:0]         i_cfg_program_length,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [2:0]              i_kind,
    input  logic [2:0]              i_reg_n,
    input  logic [2:0]              i_reg_m,
    input  logic signed [BYTE_W-1:0] i_immediate,
    input  logic [PC_W-1:0]         i_jump_target,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [PC_W-1:0]         o_next_pc,
    output logic                    o_halted,
    output logic                    o_equal_flag,
    output logic [CNT_W-1:0]        o_executed_count,
    output logic [CNT_W-1:0]        o_cycle_count,
    output logic [CNT_W-1:0]        o_local_hit_count,
    output logic [CNT_W-1:0]        o_load_store_count
);

    localparam int RIDX_W = $clog2(NUM_REGISTERS);

    // control and state
    logic              r_in_valid;
    logic              r_out_valid;
    logic [PC_W-1:0]   r_prog_len;
    logic [PC_W-1:0]   r_pc;
    logic              r_eq;
    logic              r_halted;
    logic [CNT_W-1:0]  r_instr;
    logic [CNT_W-1:0]  r_cyc;
    logic [CNT_W-1:0]  r_hit;
    logic [CNT_W-1:0]  r_ls;
    logic [BYTE_W-1:0] r_rf [NUM_REGISTERS];

    // input stage
    t_kind             r_kind;
    logic [2:0]        r_rn;
    logic [2:0]        r_rm;
    logic [BYTE_W-1:0] r_imm;
    logic [PC_W-1:0]   r_target;
    logic [BYTE_W-1:0] r_rn_val;
    logic [BYTE_W-1:0] r_rm_val;

    logic              accept;
    logic              exec;
    logic              active;
    logic [PC_W-1:0]   eff_len;

    logic              rf_we;
    logic [RIDX_W-1:0] rf_waddr;
    logic [BYTE_W-1:0] rf_wdata;
    logic              rn_ok;

    logic [PC_W-1:0]   n_pc;
    logic              n_eq;
    logic [CNT_W-1:0]  n_instr;
    logic [CNT_W-1:0]  n_cyc;
    logic [CNT_W-1:0]  n_hit;
    logic [CNT_W-1:0]  n_ls;
    logic [PC_W-1:0]   jmp_pc;

    t_mem_req          mem_req;
    logic [BYTE_W-1:0] mem_rd_data;
    logic              touched;

    logic [2:0]        nx_rn;
    logic [2:0]        nx_rm;
    logic [BYTE_W-1:0] n_rn_val;
    logic [BYTE_W-1:0] n_rm_val;

    assign exec       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || exec;
    assign accept     = i_in_valid && o_in_ready;

    assign eff_len = (CNT_W'(r_prog_len) < CNT_W'(MAX_PROGRAM)) ? r_prog_len
                                                                : PC_W'(MAX_PROGRAM);
    assign active  = r_pc < eff_len;
    assign jmp_pc  = (r_target < eff_len) ? r_target : eff_len;
    assign rn_ok   = CNT_W'(r_rn) < CNT_W'(NUM_REGISTERS);

    always_comb begin
        rf_we    = 1'b0;
        rf_waddr = RIDX_W'(r_rn);
        rf_wdata = '0;
        n_pc     = r_pc;
        n_eq     = r_eq;
        n_instr  = r_instr;
        n_cyc    = r_cyc;
        n_hit    = r_hit;
        n_ls     = r_ls;
        mem_req  = '{touch: 1'b0, wr: 1'b0, addr: r_rm_val, data: r_rn_val};
        if (exec && active) begin
            n_pc    = r_pc + PC_W'(1);
            n_instr = sat_add(r_instr, PLAIN_COST);
            n_cyc   = sat_add(r_cyc, PLAIN_COST);
            case (r_kind)
                K_MOV: begin
                    rf_we    = rn_ok;
                    rf_wdata = r_imm;
                end
                K_ADD_REG: begin
                    rf_we    = rn_ok;
                    rf_wdata = r_rn_val + r_rm_val;
                end
                K_ADD_IMM: begin
                    rf_we    = rn_ok;
                    rf_wdata = r_rn_val + r_imm;
                end
                K_CMP: begin
                    n_eq = (r_rn_val == r_rm_val);
                end
                K_JE: begin
                    if (r_eq) begin
                        n_pc = jmp_pc;
                    end
                end
                K_JMP: begin
                    n_pc = jmp_pc;
                end
                K_LD, K_ST: begin
                    mem_req.touch = 1'b1;
                    // a first-touch load clears the byte so later hits read zero
                    mem_req.wr    = (r_kind == K_ST) || !touched;
                    if (r_kind == K_LD) begin
                        mem_req.data = '0;
                    end
                    n_ls          = sat_add(r_ls, PLAIN_COST);
                    if (touched) begin
                        n_hit = sat_add(r_hit, PLAIN_COST);
                        n_cyc = sat_add(r_cyc, LOCAL_HIT_COST);
                    end else begin
                        n_cyc = sat_add(r_cyc, FIRST_TOUCH_COST);
                    end
                    if (r_kind == K_LD) begin
                        rf_we    = rn_ok;
                        rf_wdata = touched ? mem_rd_data : '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // operand reads for the item that sits in the input stage next cycle
    assign nx_rn = accept ? i_reg_n : r_rn;
    assign nx_rm = accept ? i_reg_m : r_rm;

    always_comb begin
        n_rn_val = '0;
        n_rm_val = '0;
        if (CNT_W'(nx_rn) < CNT_W'(NUM_REGISTERS)) begin
            if (rf_we && (rf_waddr == RIDX_W'(nx_rn))) begin
                n_rn_val = rf_wdata;
            end else begin
                n_rn_val = r_rf[RIDX_W'(nx_rn)];
            end
        end
        if (CNT_W'(nx_rm) < CNT_W'(NUM_REGISTERS)) begin
            if (rf_we && (rf_waddr == RIDX_W'(nx_rm))) begin
                n_rm_val = rf_wdata;
            end else begin
                n_rm_val = r_rf[RIDX_W'(nx_rm)];
            end
        end
    end

    tce_dmem u_dmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .i_rd_addr (n_rm_val),
        .o_rd_data (mem_rd_data),
        .o_touched (touched)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prog_len  <= '0;
            r_pc        <= '0;
            r_eq        <= 1'b0;
            r_halted    <= 1'b0;
            r_instr     <= '0;
            r_cyc       <= '0;
            r_hit       <= '0;
            r_ls        <= '0;
            for (int i = 0; i < NUM_REGISTERS; i++) begin
                r_rf[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_prog_len <= i_cfg_program_length;
            end
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (exec) begin
                r_in_valid <= 1'b0;
            end
            if (exec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (exec) begin
                r_pc     <= n_pc;
                r_eq     <= n_eq;
                r_halted <= !(n_pc < eff_len);
                r_instr  <= n_instr;
                r_cyc    <= n_cyc;
                r_hit    <= n_hit;
                r_ls     <= n_ls;
            end
            if (rf_we) begin
                r_rf[rf_waddr] <= rf_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= t_kind'(i_kind);
            r_rn     <= i_reg_n;
            r_rm     <= i_reg_m;
            r_imm    <= $unsigned(i_immediate);
            r_target <= i_jump_target;
        end
        r_rn_val <= n_rn_val;
        r_rm_val <= n_rm_val;
    end

    assign o_out_valid        = r_out_valid;
    assign o_next_pc          = r_pc;
    assign o_halted           = r_halted;
    assign o_equal_flag       = r_eq;
    assign o_executed_count   = r_instr;
    assign o_cycle_count      = r_cyc;
    assign o_local_hit_count  = r_hit;
    assign o_load_store_count = r_ls;

endmodule

[verif/tb_toy_cpu_execute_with_touch_cost_top.sv]
`timescale 1ns / 100ps
// Testbench for toy_cpu_execute_with_touch_cost_top: drives decoded instructions,
// predicts pc, flag and counters with its own machine model, checks every result.
// Depends on tce_pkg and the block's RTL.
module tb_toy_cpu_execute_with_touch_cost_top;
    import tce_pkg::*;

    localparam int REG_COUNT   = 6;
    localparam int PROG_CAP    = 1024;
    localparam int PC_ALL_ONES = 2047;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        t_kind           kind;
        bit [2:0]        rn;
        bit [2:0]        rm;
        bit [BYTE_W-1:0] imm;
        bit [PC_W-1:0]   target;
    } t_instr;

    typedef struct {
        logic [PC_W-1:0]  next_pc;
        logic             halted;
        logic             eq;
        logic [CNT_W-1:0] executed;
        logic [CNT_W-1:0] cycles;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] accesses;
    } t_status;

    class t_execute_tracker;
        bit [BYTE_W-1:0] regs [REG_COUNT];
        bit [BYTE_W-1:0] mem [MEM_BYTES];
        bit              touched [MEM_BYTES];
        bit              eq;
        bit [PC_W-1:0]   pc;
        bit [PC_W-1:0]   plen;
        bit [CNT_W-1:0]  executed, cycles, hits, accesses;
        t_status         status_due[$];
        int              errors;

        function bit [PC_W-1:0] eff_len(bit [PC_W-1:0] len);
            return (len < PROG_CAP) ? len : PC_W'(PROG_CAP);
        endfunction

        function bit [CNT_W-1:0] bump(bit [CNT_W-1:0] a, bit [CNT_W-1:0] b);
            return (a > ~b) ? '1 : a + b;
        endfunction

        function bit [BYTE_W-1:0] get(bit [2:0] idx);
            return (idx < REG_COUNT) ? regs[idx] : '0;
        endfunction

        function void put(bit [2:0] idx, bit [BYTE_W-1:0] v);
            if (idx < REG_COUNT) regs[idx] = v;
        endfunction

        function void touch(bit [ADDR_W-1:0] a);
            accesses = bump(accesses, 1);
            if (touched[a]) begin
                hits   = bump(hits, 1);
                cycles = bump(cycles, LOCAL_HIT_COST);
            end else begin
                touched[a] = 1'b1;
                cycles     = bump(cycles, FIRST_TOUCH_COST);
            end
        endfunction

        function void retire(t_instr ins);
            bit [PC_W-1:0]   len;
            bit [PC_W-1:0]   nxt;
            bit [ADDR_W-1:0] a;
            t_status         s;
            len = eff_len(plen);
            if (pc < len) begin
                nxt      = pc + 1'b1;
                executed = bump(executed, 1);
                if (ins.kind != K_LD && ins.kind != K_ST) cycles = bump(cycles, PLAIN_COST);
                case (ins.kind)
                    K_MOV:     put(ins.rn, ins.imm);
                    K_ADD_REG: put(ins.rn, get(ins.rn) + get(ins.rm));
                    K_ADD_IMM: put(ins.rn, get(ins.rn) + ins.imm);
                    K_CMP:     eq = (get(ins.rn) == get(ins.rm));
                    K_JE, K_JMP: begin
                        if (ins.kind == K_JMP || eq) nxt = (ins.target < len) ? ins.target : len;
                    end
                    K_LD: begin
                        a = get(ins.rm);
                        touch(a);
                        put(ins.rn, mem[a]);
                    end
                    K_ST: begin
                        a = get(ins.rm);
                        touch(a);
                        mem[a] = get(ins.rn);
                    end
                    default: ;
                endcase
                pc = nxt;
            end
            s.next_pc  = pc;
            s.halted   = (pc >= len);
            s.eq       = eq;
            s.executed = executed;
            s.cycles   = cycles;
            s.hits     = hits;
            s.accesses = accesses;
            status_due.push_back(s);
        endfunction

        function void diff(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        function void compare_status(t_status got);
            t_status want;
            if (status_due.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none actual pc %0h", $time,
                         got.next_pc);
            end else begin
                want = status_due.pop_front();
                diff("next_pc", want.next_pc, got.next_pc);
                diff("halted", want.halted, got.halted);
                diff("equal_flag", want.eq, got.eq);
                diff("executed_count", want.executed, got.executed);
                diff("cycle_count", want.cycles, got.cycles);
                diff("local_hit_count", want.hits, got.hits);
                diff("load_store_count", want.accesses, got.accesses);
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [PC_W-1:0]          i_cfg_program_length = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [2:0]               i_kind = '0;
    logic [2:0]               i_reg_n = '0;
    logic [2:0]               i_reg_m = '0;
    logic signed [BYTE_W-1:0] i_immediate = '0;
    logic [PC_W-1:0]          i_jump_target = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [PC_W-1:0]          o_next_pc;
    logic                     o_halted;
    logic                     o_equal_flag;
    logic [CNT_W-1:0]         o_executed_count;
    logic [CNT_W-1:0]         o_cycle_count;
    logic [CNT_W-1:0]         o_local_hit_count;
    logic [CNT_W-1:0]         o_load_store_count;

    t_execute_tracker trk = new();
    int               send_idle = 0;
    int               rx_stall = 0;
    int               clk_ticks = 0;

    toy_cpu_execute_with_touch_cost_top #(
        .NUM_REGISTERS(REG_COUNT),
        .MAX_PROGRAM  (PROG_CAP)
    ) DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_program_length(i_cfg_program_length),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_kind              (i_kind),
        .i_reg_n             (i_reg_n),
        .i_reg_m             (i_reg_m),
        .i_immediate         (i_immediate),
        .i_jump_target       (i_jump_target),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_next_pc           (o_next_pc),
        .o_halted            (o_halted),
        .o_equal_flag        (o_equal_flag),
        .o_executed_count    (o_executed_count),
        .o_cycle_count       (o_cycle_count),
        .o_local_hit_count   (o_local_hit_count),
        .o_load_store_count  (o_load_store_count)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        clk_ticks <= clk_ticks + 1;
        if (clk_ticks == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_status got;
        got.next_pc  = o_next_pc;
        got.halted   = o_halted;
        got.eq       = o_equal_flag;
        got.executed = o_executed_count;
        got.cycles   = o_cycle_count;
        got.hits     = o_local_hit_count;
        got.accesses = o_load_store_count;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) trk.compare_status(got);
        i_out_ready <= ($urandom_range(99) >= rx_stall);
    end

    task automatic push_instr(t_kind k, bit [2:0] rn, bit [2:0] rm, bit [BYTE_W-1:0] imm,
                              bit [PC_W-1:0] tgt);
        t_instr ins;
        ins = '{kind: k, rn: rn, rm: rm, imm: imm, target: tgt};
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= k;
        i_reg_n       <= rn;
        i_reg_m       <= rm;
        i_immediate   <= imm;
        i_jump_target <= tgt;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        trk.retire(ins);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (trk.status_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_length(bit [PC_W-1:0] len);
        wait_drain();
        i_cfg_we             <= 1'b1;
        i_cfg_program_length <= len;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        trk.plen = len;
    endtask

    // pc sitting at or past the new length: open up, jump home, then narrow
    task automatic resume(bit [PC_W-1:0] len);
        if (trk.pc >= trk.eff_len(len)) begin
            write_length(PC_W'(PROG_CAP));
            push_instr(K_JMP, 3'($urandom), 3'($urandom), 8'($urandom), '0);
        end
        write_length(len);
    endtask

    task automatic push_random();
        bit [PC_W-1:0] len;
        t_kind         k;
        bit [2:0]      rn, rm;
        bit [PC_W-1:0] tgt;
        len = trk.eff_len(trk.plen);
        k   = t_kind'($urandom_range(7));
        rn  = ($urandom_range(99) < 85) ? 3'($urandom_range(REG_COUNT - 1))
                                        : 3'($urandom_range(7));
        rm  = ($urandom_range(99) < 85) ? 3'($urandom_range(REG_COUNT - 1))
                                        : 3'($urandom_range(7));
        if ($urandom_range(99) < 85 || len == PROG_CAP) tgt = PC_W'($urandom_range(len - 1));
        else tgt = PC_W'($urandom_range(PC_ALL_ONES, len));
        // at full capacity the pc must never reach the end
        if (len == PROG_CAP && trk.pc == PROG_CAP - 1) k = K_JMP;
        push_instr(k, rn, rm, 8'($urandom), tgt);
    endtask

    task automatic random_phase(bit [PC_W-1:0] len, int n, int idle, int stall);
        int done;
        send_idle = idle;
        rx_stall  = stall;
        resume(len);
        done = 0;
        while (done < n) begin
            if (trk.pc >= trk.eff_len(trk.plen)) begin
                if ($urandom_range(1)) push_random();
                resume(len);
            end else begin
                push_random();
                done++;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero length: halted from the start, item ignored
        push_instr(K_MOV, 3'd0, 3'd0, 8'h5A, '0);
        write_length(11'd40);

        push_instr(K_MOV, 3'd0, 3'd0, 8'h80, '0);
        push_instr(K_MOV, 3'd1, 3'd0, 8'h7F, '0);
        push_instr(K_MOV, 3'd5, 3'd0, 8'hFF, '0);
        push_instr(K_ADD_REG, 3'd0, 3'd1, 8'h00, '0);
        push_instr(K_ADD_IMM, 3'd0, 3'd0, 8'h01, '0);
        push_instr(K_ADD_IMM, 3'd1, 3'd0, 8'h80, '0);
        push_instr(K_CMP, 3'd0, 3'd2, 8'h00, '0);
        push_instr(K_JE, 3'd0, 3'd0, 8'h00, 11'd10);
        push_instr(K_CMP, 3'd0, 3'd1, 8'h00, '0);
        push_instr(K_JE, 3'd0, 3'd0, 8'h00, 11'd3);
        push_instr(K_JMP, 3'd0, 3'd0, 8'h00, 11'd20);
        push_instr(K_MOV, 3'd6, 3'd0, 8'h55, '0);
        push_instr(K_ADD_REG, 3'd2, 3'd7, 8'h00, '0);
        push_instr(K_CMP, 3'd6, 3'd7, 8'h00, '0);
        push_instr(K_ST, 3'd5, 3'd0, 8'h00, '0);
        push_instr(K_LD, 3'd3, 3'd0, 8'h00, '0);
        push_instr(K_LD, 3'd4, 3'd7, 8'h00, '0);
        push_instr(K_ST, 3'd1, 3'd5, 8'h00, '0);
        push_instr(K_LD, 3'd6, 3'd5, 8'h00, '0);
        push_instr(K_JMP, 3'd7, 3'd7, 8'h00, PC_W'(PC_ALL_ONES));
        push_instr(K_ADD_IMM, 3'd0, 3'd0, 8'h01, '0);

        random_phase(11'd1023, 250, 0, 0);
        random_phase(11'd2, 80, 72, 0);
        random_phase(11'd1024, 300, 0, 72);
        random_phase(11'd17, 250, 23, 23);
        random_phase(11'd2047, 250, 0, 0);
        random_phase(11'd1, 40, 72, 0);
        random_phase(11'd600, 250, 0, 72);
        random_phase(11'd1000, 250, 23, 23);

        // oversized length: a jump past the end parks the pc at capacity
        write_length(PC_W'(PC_ALL_ONES));
        push_instr(K_JMP, 3'd0, 3'd0, 8'h00, PC_W'(PC_ALL_ONES));
        push_instr(K_ST, 3'd5, 3'd0, 8'h00, '0);
        wait_drain();
        repeat (8) @(posedge i_clk);
        if (trk.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
